// ----- hdl/particle_velocity_integrator_unit_defines.svh -----
// Assertion helpers for the particle velocity integrator.
`ifndef PARTICLE_VELOCITY_INTEGRATOR_UNIT_DEFINES_SVH
`define PARTICLE_VELOCITY_INTEGRATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PVI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PVI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pvi_pkg.sv -----
package pvi_pkg;

  localparam int SQ_STG   = 16;  // two root bits per stage
  localparam int DV_STG   = 12;  // two quotient bits per stage
  localparam int CARRY_STG = SQ_STG + DV_STG;
  localparam int PIPE_STG = 5 + CARRY_STG;

  typedef enum logic [1:0] {
    CMD_INT  = 2'd0,
    CMD_WRAP = 2'd1,
    CMD_LOAD = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_FRICTION = 3'd0,
    REG_MAX_SPD  = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_HEIGHT   = 3'd3,
    REG_COUNT    = 3'd4
  } reg_e;

  typedef struct packed {
    logic       vld;
    logic       err;
    logic [9:0] idx;
  } tag_t;

  typedef struct packed {
    logic        is_int;
    logic        clamp;
    logic [63:0] pos;
    logic [63:0] vel;
  } carry_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  function automatic sq_t sq_step(sq_t s, logic [1:0] nb);
    logic [35:0] r;
    logic [35:0] t;
    sq_t         o;
    r = {s.rem, nb};
    t = {2'b00, s.root, 2'b01};
    if (r >= t) begin
      o.rem  = 34'(r - t);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = r[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // returns {quotient bit, remainder}
  function automatic logic [33:0] dv_step(logic [32:0] r, logic b, logic [31:0] m);
    logic [33:0] t;
    logic [33:0] o;
    t = {r, b};
    if (t >= {2'b00, m}) begin
      o = {1'b1, 33'(t - {2'b00, m})};
    end else begin
      o = {1'b0, t[32:0]};
    end
    return o;
  endfunction

  function automatic logic [31:0] sat32(logic signed [33:0] v);
    logic [31:0] o;
    if (v > 34'sd2147483647) begin
      o = 32'h7fff_ffff;
    end else if (v < -34'sd2147483648) begin
      o = 32'h8000_0000;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

  function automatic logic [31:0] wrap_axis(logic [31:0] p, logic [12:0] sz);
    logic signed [33:0] t;
    logic signed [33:0] w;
    t = 34'($signed(p));
    w = $signed({5'b0, sz, 16'b0});
    if (t < 0) begin
      t = t + w;
    end
    if (t > w) begin
      t = t - w;
    end
    return t[31:0];
  endfunction

endpackage

// ----- hdl/particle_velocity_integrator_unit.sv -----
// Channel  Dir  Handshake              Payload
// s_axis   in   tvalid/tready          tuser cmd; tdata index, vec x, vec y
// m_axis   out  tvalid/tready          tuser index_error; tdata index, pos, vel
// apb      in   psel/penable/pready    five config registers at 4*i
//
// One request per cycle unless a stalled output or a vertex hazard holds the input.
// Requests pass through the 16-stage square root and 12-stage divider in line.
// A request for a vertex still in flight waits until that vertex is written
// back, since state is read at entry and written at exit.
// A stalled output freezes the whole pipeline. No clearing pass after reset.
module particle_velocity_integrator_unit
  import pvi_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,  // vertex_index, vec_x, vec_y
  input  logic [1:0]   s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,  // out_index, pos_x, pos_y, vel_x, vel_y
  output logic         m_axis_tuser,  // index_error
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  // configuration
  logic [15:0] fric_q;
  logic [23:0] lim_q;
  logic [12:0] fw_q;
  logic [12:0] fh_q;
  logic [10:0] vcnt_q;
  logic [47:0] lim2_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fric_q <= 16'd0;
      lim_q  <= 24'hff_ffff;
      fw_q   <= 13'd1024;
      fh_q   <= 13'd768;
      vcnt_q <= 11'd0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_e'(paddr[4:2]))
        REG_FRICTION: fric_q <= pwdata[15:0];
        REG_MAX_SPD:  lim_q  <= pwdata[23:0];
        REG_WIDTH:    fw_q   <= pwdata[12:0];
        REG_HEIGHT:   fh_q   <= pwdata[12:0];
        REG_COUNT:    vcnt_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    lim2_q <= lim_q * lim_q;
  end

  always_comb begin
    unique case (reg_e'(paddr[4:2]))
      REG_FRICTION: prdata = {16'd0, fric_q};
      REG_MAX_SPD:  prdata = {8'd0, lim_q};
      REG_WIDTH:    prdata = {19'd0, fw_q};
      REG_HEIGHT:   prdata = {19'd0, fh_q};
      REG_COUNT:    prdata = {21'd0, vcnt_q};
      default:      prdata = 32'd0;
    endcase
  end

  // input side
  logic        adv;
  logic        hazard;
  logic        acc;
  logic        in_err;
  logic [9:0]  in_idx;
  logic [16:0] in_ext;
  logic [AW-1:0] raddr;
  logic        mvld_q;
  tag_t        tag_q [PIPE_STG];

  assign in_idx = s_axis_tdata[9:0];
  assign in_ext = 17'(in_idx);
  assign raddr  = in_ext[AW-1:0];
  assign in_err = ({1'b0, in_idx} >= vcnt_q) || (in_ext >= 17'(MAX_VERTICES));
  assign adv    = !mvld_q || m_axis_tready;

  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < PIPE_STG; k++) begin
      hazard = hazard | (tag_q[k].vld && !tag_q[k].err && (tag_q[k].idx == in_idx));
    end
  end

  assign s_axis_tready = adv && !hazard;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_STG; k++) begin
        tag_q[k] <= '0;
      end
    end else if (adv) begin
      tag_q[0] <= acc ? tag_t'{vld: 1'b1, err: in_err, idx: in_idx} : '0;
      for (int k = 1; k < PIPE_STG; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  // state memories, {y, x}
  logic [63:0] pos_mem [MAX_VERTICES];
  logic [63:0] vel_mem [MAX_VERTICES];
  logic [63:0] pos_rd_q;
  logic [63:0] vel_rd_q;
  logic        wen;
  logic [16:0] w_ext;
  logic [AW-1:0] waddr;
  logic [63:0] pos_wr;
  logic [63:0] vel_wr;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_rd_q <= pos_mem[raddr];
    end
    if (wen) begin
      pos_mem[waddr] <= pos_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vel_rd_q <= vel_mem[raddr];
    end
    if (wen) begin
      vel_mem[waddr] <= vel_wr;
    end
  end

  // stage A: request fields
  cmd_e        cmd_a_q;
  logic [63:0] acc_a_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd_a_q <= cmd_e'(s_axis_tuser);
      acc_a_q <= s_axis_tdata[73:10];
    end
  end

  // stage B: friction products
  logic signed [48:0] px_b_q;
  logic signed [48:0] py_b_q;
  cmd_e        cmd_b_q;
  logic [63:0] acc_b_q;
  logic [63:0] pos_b_q;
  logic [63:0] vel_b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_b_q  <= $signed(vel_rd_q[31:0]) * $signed({1'b0, fric_q});
      py_b_q  <= $signed(vel_rd_q[63:32]) * $signed({1'b0, fric_q});
      cmd_b_q <= cmd_a_q;
      acc_b_q <= acc_a_q;
      pos_b_q <= pos_rd_q;
      vel_b_q <= vel_rd_q;
    end
  end

  // stage C: new velocity, per-command state
  logic signed [33:0] sum_x;
  logic signed [33:0] sum_y;
  logic [63:0] p_c_d;
  logic [63:0] v_c_d;
  logic [63:0] p_c_q;
  logic [63:0] v_c_q;
  logic        int_c_q;

  always_comb begin
    sum_x = 34'($signed(vel_b_q[31:0])) + 34'($signed(acc_b_q[31:0]))
          - 34'(px_b_q >>> 16);
    sum_y = 34'($signed(vel_b_q[63:32])) + 34'($signed(acc_b_q[63:32]))
          - 34'(py_b_q >>> 16);
    case (cmd_b_q)
      CMD_INT: begin
        p_c_d = pos_b_q;
        v_c_d = {sat32(sum_y), sat32(sum_x)};
      end
      CMD_WRAP: begin
        p_c_d = {wrap_axis(pos_b_q[63:32], fh_q), wrap_axis(pos_b_q[31:0], fw_q)};
        v_c_d = vel_b_q;
      end
      CMD_LOAD: begin
        p_c_d = acc_b_q;
        v_c_d = 64'd0;
      end
      default: begin
        p_c_d = pos_b_q;
        v_c_d = vel_b_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_c_q   <= p_c_d;
      v_c_q   <= v_c_d;
      int_c_q <= (cmd_b_q == CMD_INT);
    end
  end

  // stage D: squares and scaled magnitudes
  logic [31:0] ux;
  logic [31:0] uy;
  logic [63:0] sqx_d_q;
  logic [63:0] sqy_d_q;
  logic [55:0] dvx_d_q;
  logic [55:0] dvy_d_q;
  logic [63:0] p_d_q;
  logic [63:0] v_d_q;
  logic        int_d_q;

  assign ux = v_c_q[31] ? 32'(-v_c_q[31:0]) : v_c_q[31:0];
  assign uy = v_c_q[63] ? 32'(-v_c_q[63:32]) : v_c_q[63:32];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_d_q <= ux * ux;
      sqy_d_q <= uy * uy;
      dvx_d_q <= ux * lim_q;
      dvy_d_q <= uy * lim_q;
      p_d_q   <= p_c_q;
      v_d_q   <= v_c_q;
      int_d_q <= int_c_q;
    end
  end

  // stage E: magnitude squared and limit test
  logic [63:0] m2_e_q;
  logic [63:0] m2;
  carry_t      car_e_q;
  logic [111:0] dv_e_q;

  assign m2 = sqx_d_q + sqy_d_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_e_q  <= m2;
      car_e_q <= carry_t'{is_int: int_d_q,
                          clamp:  int_d_q && (m2 > {16'd0, lim2_q}),
                          pos:    p_d_q,
                          vel:    v_d_q};
      dv_e_q  <= {dvy_d_q, dvx_d_q};
    end
  end

  // root, then divide; side data travels alongside
  carry_t       car_q [CARRY_STG];
  logic [111:0] dvl_q [SQ_STG];
  logic [31:0]  mag;
  logic [23:0]  qx;
  logic [23:0]  qy;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      car_q[0] <= car_e_q;
      for (int k = 1; k < CARRY_STG; k++) begin
        car_q[k] <= car_q[k-1];
      end
      dvl_q[0] <= dv_e_q;
      for (int k = 1; k < SQ_STG; k++) begin
        dvl_q[k] <= dvl_q[k-1];
      end
    end
  end

  pvi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (m2_e_q),
    .root_o (mag)
  );

  pvi_div u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .dvd_i (dvl_q[SQ_STG-1][55:0]),
    .dvs_i (mag),
    .quo_o (qx)
  );

  pvi_div u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .dvd_i (dvl_q[SQ_STG-1][111:56]),
    .dvs_i (mag),
    .quo_o (qy)
  );

  // final: limit, position update, write back
  carry_t      fin;
  tag_t        ftag;
  logic [31:0] fvx;
  logic [31:0] fvy;
  logic [31:0] fpx;
  logic [31:0] fpy;
  logic [143:0] mdata_q;
  logic        muser_q;

  assign fin  = car_q[CARRY_STG-1];
  assign ftag = tag_q[PIPE_STG-1];

  always_comb begin
    if (fin.clamp) begin
      fvx = fin.vel[31] ? 32'(-{8'd0, qx}) : {8'd0, qx};
      fvy = fin.vel[63] ? 32'(-{8'd0, qy}) : {8'd0, qy};
    end else begin
      fvx = fin.vel[31:0];
      fvy = fin.vel[63:32];
    end
    if (fin.is_int) begin
      fpx = sat32(34'($signed(fin.pos[31:0])) + 34'($signed(fvx)));
      fpy = sat32(34'($signed(fin.pos[63:32])) + 34'($signed(fvy)));
    end else begin
      fpx = fin.pos[31:0];
      fpy = fin.pos[63:32];
    end
  end

  assign pos_wr = {fpy, fpx};
  assign vel_wr = {fvy, fvx};
  assign wen    = adv && ftag.vld && !ftag.err;
  assign w_ext  = 17'(ftag.idx);
  assign waddr  = w_ext[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q <= 1'b0;
    end else if (adv) begin
      mvld_q <= ftag.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      muser_q <= ftag.err;
      if (ftag.err) begin
        mdata_q <= {134'd0, ftag.idx};
      end else begin
        mdata_q <= {6'd0, fvy, fvx, fpy, fpx, ftag.idx};
      end
    end
  end

  assign m_axis_tvalid = mvld_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = muser_q;

endmodule

// ----- hdl/pvi_sqrt.sv -----
module pvi_sqrt
  import pvi_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  sq_t         st_q [SQ_STG];
  logic [63:0] n_q  [SQ_STG];

  for (genvar g = 0; g < SQ_STG; g++) begin : g_stg
    sq_t         s_in;
    logic [63:0] n_in;
    sq_t         s_a;
    sq_t         s_b;

    if (g == 0) begin : g_first
      assign s_in = '0;
      assign n_in = rad_i;
    end else begin : g_next
      assign s_in = st_q[g-1];
      assign n_in = n_q[g-1];
    end

    always_comb begin
      s_a = sq_step(s_in, n_in[63:62]);
      s_b = sq_step(s_a, n_in[61:60]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g] <= s_b;
        n_q[g]  <= {n_in[59:0], 4'b0};
      end
    end
  end

  assign root_o = st_q[SQ_STG-1].root;

endmodule

// ----- hdl/pvi_div.sv -----
module pvi_div
  import pvi_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [55:0] dvd_i,
  input  logic [31:0] dvs_i,
  output logic [23:0] quo_o
);

  logic [32:0] r_q  [DV_STG];
  logic [23:0] q_q  [DV_STG];
  logic [23:0] lo_q [DV_STG];
  logic [31:0] m_q  [DV_STG];

  for (genvar g = 0; g < DV_STG; g++) begin : g_stg
    logic [32:0] r_in;
    logic [23:0] q_in;
    logic [23:0] lo_in;
    logic [31:0] m_in;
    logic [33:0] s_a;
    logic [33:0] s_b;

    if (g == 0) begin : g_first
      assign r_in  = {1'b0, dvd_i[55:24]};
      assign q_in  = '0;
      assign lo_in = dvd_i[23:0];
      assign m_in  = dvs_i;
    end else begin : g_next
      assign r_in  = r_q[g-1];
      assign q_in  = q_q[g-1];
      assign lo_in = lo_q[g-1];
      assign m_in  = m_q[g-1];
    end

    always_comb begin
      s_a = dv_step(r_in, lo_in[23], m_in);
      s_b = dv_step(s_a[32:0], lo_in[22], m_in);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g]  <= s_b[32:0];
        q_q[g]  <= {q_in[21:0], s_a[33], s_b[33]};
        lo_q[g] <= {lo_in[21:0], 2'b00};
        m_q[g]  <= m_in;
      end
    end
  end

  assign quo_o = q_q[DV_STG-1];

endmodule

// ----- hdl/pvi_checker.sv -----
`include "particle_velocity_integrator_unit_defines.svh"

module pvi_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         psel,
  input logic         pwrite,
  input logic [31:0]  prdata
);

  `PVI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `PVI_ASSERT_NOW(a_stall_blocks_in, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "request taken while pipeline frozen")
  `PVI_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[143:10] == 134'd0, "rejected index carries state")
  `PVI_ASSERT_NOW(a_reg_width, psel && !pwrite, prdata[31:24] == 8'h00, "register read beyond width")

endmodule

bind particle_velocity_integrator_unit pvi_checker u_pvi_checker (.*);

// ----- tb/sv/particle_state_checker.sv -----
`timescale 1ns / 100ps

module particle_state_checker
  import pvi_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [79:0]  s_tdata_i,   // vertex_index, vec_x, vec_y
  input  logic [1:0]   s_tuser_i,   // cmd
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [143:0] m_tdata_i,   // out_index, pos_x, pos_y, vel_x, vel_y
  input  logic         m_tuser_i,   // index_error
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic         pready_i,
  input  logic [4:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct {
    logic [9:0]  idx;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic        err;
  } vertex_state_t;

  vertex_state_t expected_states[$];

  longint pos_x_mem[1024];
  longint pos_y_mem[1024];
  longint vel_x_mem[1024];
  longint vel_y_mem[1024];

  logic [15:0] friction;
  logic [23:0] speed_lim;
  logic [12:0] field_w;
  logic [12:0] field_h;
  logic [10:0] vtx_count;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bit_v;
    root  = 0;
    bit_v = 64'h1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n    = n - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic longint limit_comp(longint v, longint unsigned lim,
                                        longint unsigned mag);
    longint unsigned a;
    longint unsigned q;
    a = (v < 0) ? longint'(-v) : v;
    q = (a * lim) / mag;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint wrap_pos(longint p, logic [12:0] sz);
    longint w;
    w = longint'(sz) * 65536;
    if (p < 0) p = p + w;
    if (p > w) p = p - w;
    return p;
  endfunction

  function automatic vertex_state_t advance_vertex(logic [1:0] cmd_raw, logic [79:0] d);
    vertex_state_t   r;
    logic [9:0]      idx;
    longint          ax, ay, vx, vy;
    longint unsigned ux, uy, m2, lim, mag;
    cmd_e            cmd;
    idx = d[9:0];
    ax  = longint'($signed(d[41:10]));
    ay  = longint'($signed(d[73:42]));
    cmd = cmd_e'(cmd_raw);
    r   = '{idx: idx, px: '0, py: '0, vx: '0, vy: '0, err: 1'b0};
    if (idx >= vtx_count) begin
      r.err = 1'b1;
      return r;
    end
    case (cmd)
      CMD_INT: begin
        vx = vel_x_mem[idx];
        vy = vel_y_mem[idx];
        vx = clip32(vx + ax - ((vx * longint'(friction)) >>> 16));
        vy = clip32(vy + ay - ((vy * longint'(friction)) >>> 16));
        ux = (vx < 0) ? longint'(-vx) : vx;
        uy = (vy < 0) ? longint'(-vy) : vy;
        m2 = ux * ux + uy * uy;
        lim = speed_lim;
        if (m2 > lim * lim) begin
          mag = int_sqrt(m2);
          vx  = limit_comp(vx, lim, mag);
          vy  = limit_comp(vy, lim, mag);
        end
        vel_x_mem[idx] = vx;
        vel_y_mem[idx] = vy;
        pos_x_mem[idx] = clip32(pos_x_mem[idx] + vx);
        pos_y_mem[idx] = clip32(pos_y_mem[idx] + vy);
      end
      CMD_WRAP: begin
        pos_x_mem[idx] = wrap_pos(pos_x_mem[idx], field_w);
        pos_y_mem[idx] = wrap_pos(pos_y_mem[idx], field_h);
      end
      CMD_LOAD: begin
        pos_x_mem[idx] = ax;
        pos_y_mem[idx] = ay;
        vel_x_mem[idx] = 0;
        vel_y_mem[idx] = 0;
      end
      default: ;
    endcase
    r.px = pos_x_mem[idx][31:0];
    r.py = pos_y_mem[idx][31:0];
    r.vx = vel_x_mem[idx][31:0];
    r.vy = vel_y_mem[idx][31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_state_t want;
    if (!rst_ni) begin
      friction     = '0;
      speed_lim    = 24'hFF_FFFF;
      field_w      = 13'd1024;
      field_h      = 13'd768;
      vtx_count    = '0;
      fail_count_o = 0;
      expected_states.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_states.size() == 0) begin
          report_mismatch("unexpected result", m_tdata_i[31:0], '0);
        end else begin
          want = expected_states.pop_front();
          if (m_tdata_i[9:0] != want.idx)
            report_mismatch("index", 32'(m_tdata_i[9:0]), 32'(want.idx));
          if (m_tdata_i[41:10] != want.px) report_mismatch("pos_x", m_tdata_i[41:10], want.px);
          if (m_tdata_i[73:42] != want.py) report_mismatch("pos_y", m_tdata_i[73:42], want.py);
          if (m_tdata_i[105:74] != want.vx) report_mismatch("vel_x", m_tdata_i[105:74], want.vx);
          if (m_tdata_i[137:106] != want.vy)
            report_mismatch("vel_y", m_tdata_i[137:106], want.vy);
          if (m_tuser_i != want.err)
            report_mismatch("index_error", 32'(m_tuser_i), 32'(want.err));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[4:2]))
          REG_FRICTION: friction  = pwdata_i[15:0];
          REG_MAX_SPD:  speed_lim = pwdata_i[23:0];
          REG_WIDTH:    field_w   = pwdata_i[12:0];
          REG_HEIGHT:   field_h   = pwdata_i[12:0];
          REG_COUNT:    vtx_count = pwdata_i[10:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_states.push_back(advance_vertex(s_tuser_i, s_tdata_i));
      end
    end
    pending_o = expected_states.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import pvi_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;   // vertex_index, vec_x, vec_y
  logic [1:0]   s_axis_tuser = '0;   // cmd
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;        // out_index, pos_x, pos_y, vel_x, vel_y
  logic         m_axis_tuser;        // index_error
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int cur_count;
  bit loaded[1024];

  always #5 clk_i = ~clk_i;

  particle_velocity_integrator_unit u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  particle_state_checker u_chk (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic apb_write(reg_e r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_COUNT) cur_count = int'(v[10:0]);
  endtask

  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_request(cmd_e cmd, logic [9:0] idx, logic [31:0] x, logic [31:0] y);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'b0, y, x, idx};
    if (cmd == CMD_LOAD && idx < cur_count) loaded[idx] = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_accel();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(5))
      0: return $urandom;
      1: return -($urandom_range(0, 32'h40_0000));
      default: return $urandom_range(0, 32'h1000_0000);
    endcase
  endfunction

  task automatic random_request();
    int   r;
    int   hi;
    logic [9:0] idx;
    r = $urandom_range(99);
    if ((cur_count < 1024 && r < 6) || cur_count == 0) begin
      if (cur_count < 1024) begin
        send_request(cmd_e'($urandom_range(3)), 10'($urandom_range(cur_count, 1023)),
                     $urandom, $urandom);
        return;
      end
    end
    hi  = (cur_count > 48) ? 48 : cur_count;
    idx = (r < 16) ? 10'($urandom_range(0, cur_count - 1)) : 10'($urandom_range(0, hi - 1));
    if (!loaded[idx] || r < 22) send_request(CMD_LOAD, idx, pick_pos(), pick_pos());
    else if (r < 75) send_request(CMD_INT, idx, pick_accel(), pick_accel());
    else if (r < 93) send_request(CMD_WRAP, idx, $urandom, $urandom);
    else send_request(CMD_NOP, idx, $urandom, $urandom);
  endtask

  task automatic set_config(logic [31:0] fr, logic [31:0] spd, logic [31:0] w,
                            logic [31:0] h, logic [31:0] cnt);
    apb_write(REG_FRICTION, fr);
    apb_write(REG_MAX_SPD, spd);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_COUNT, cnt);
  endtask

  initial begin
    idle_pct  = 0;
    stall_pct = 0;
    cur_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // count is zero after reset: everything flagged
    send_request(CMD_LOAD, 10'd0, 32'h1, 32'h2);
    send_request(CMD_INT, 10'd1023, 32'hFFFF_FFFF, 32'h0);
    drain_pipe();
    apb_write(REG_COUNT, 32'd1024);
    send_request(CMD_LOAD, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_INT, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_INT, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_WRAP, 10'd0, 32'h0, 32'h0);
    send_request(CMD_NOP, 10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_LOAD, 10'd1023, 32'hFFF0_0000, 32'h1000_0000);
    send_request(CMD_WRAP, 10'd1023, 32'h0, 32'h0);
    send_request(CMD_INT, 10'd1023, 32'h0001_0000, 32'hFFFF_0000);
    send_request(CMD_INT, 10'd1023, 32'h0, 32'h0);
    send_request(CMD_LOAD, 10'd512, 32'h0400_0000, 32'h0300_0000);
    send_request(CMD_WRAP, 10'd512, 32'h0, 32'h0);
    send_request(CMD_NOP, 10'd512, 32'h0, 32'h0);
    drain_pipe();
    set_config(32'hFFFF, 32'h0, 32'h0, 32'h0, 32'd700);
    send_request(CMD_INT, 10'd512, 32'h0010_0000, 32'h0010_0000);
    send_request(CMD_WRAP, 10'd512, 32'h0, 32'h0);
    send_request(CMD_INT, 10'd1023, 32'h0, 32'h0);
    send_request(CMD_LOAD, 10'd700, 32'h0, 32'h0);
    send_request(CMD_INT, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF);

    for (int p = 0; p < 5; p++) begin
      drain_pipe();
      case (p)
        0: begin
          idle_pct = 0;  stall_pct = 0;
          set_config(32'h0, 32'hFF_FFFF, 32'd4096, 32'd4096, 32'd1024);
        end
        1: begin
          idle_pct = 55; stall_pct = 0;
          set_config(32'hFFFF, 32'h0, 32'd1, 32'd1, 32'd1024);
        end
        2: begin
          idle_pct = 0;  stall_pct = 55;
          set_config($urandom, $urandom_range(32'h2_0000, 32'h10_0000),
                     $urandom_range(1, 4096), 32'h0, $urandom_range(1, 1024));
        end
        3: begin
          idle_pct = 38; stall_pct = 38;
          set_config($urandom, $urandom, 32'h0, $urandom_range(1, 4096), 32'd1);
        end
        default: begin
          idle_pct = 0;  stall_pct = 0;
          set_config($urandom_range(0, 4000), 32'h8_0000, 32'd640, 32'd480, 32'd1024);
        end
      endcase
      for (int i = 0; i < 170; i++) begin
        if (p == 2 && i == 85) begin
          s_axis_tvalid <= 1'b0;
          @(negedge clk_i);
          while (pending != 0) @(negedge clk_i);
          @(posedge clk_i);
        end
        random_request();
      end
    end

    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
